// File: src/tcw_pkg.sv
// Shared types and constants of the text console character writer.
// Field widths, command and result codes, register indexes, reset values.
// No dependencies; imported by the core.
package tcw_pkg;

  // Geometry defaults for the core parameters.
  localparam int ROWS_DEFAULT    = 14;
  localparam int COLUMNS_DEFAULT = 37;

  // Port field widths.
  localparam int KIND_WIDTH      = 2;
  localparam int CHAR_CODE_WIDTH = 8;
  localparam int COLUMN_WIDTH    = 6;
  localparam int ROW_WIDTH       = 4;
  localparam int ACTION_WIDTH    = 2;
  localparam int GLYPH_WIDTH     = 7;
  localparam int PIXEL_X_WIDTH   = 11;
  localparam int PIXEL_Y_WIDTH   = 10;
  localparam int ORIGIN_WIDTH    = 9;
  localparam int CELL_SIZE_WIDTH = 5;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 9;

  // Register reset values.
  localparam logic [ORIGIN_WIDTH-1:0]    ORIGIN_X_RESET    = 9'd17;
  localparam logic [CELL_SIZE_WIDTH-1:0] CELL_WIDTH_RESET  = 5'd12;
  localparam logic [ORIGIN_WIDTH-1:0]    ORIGIN_Y_RESET    = 9'd47;
  localparam logic [CELL_SIZE_WIDTH-1:0] CELL_HEIGHT_RESET = 5'd18;

  // Character codes.
  localparam logic [CHAR_CODE_WIDTH-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_CODE_WIDTH-1:0] CHAR_LF        = 8'd10;
  localparam logic [CHAR_CODE_WIDTH-1:0] CHAR_CR        = 8'd13;
  localparam logic [CHAR_CODE_WIDTH-1:0] CHAR_PRINT_LO  = 8'd32;
  localparam logic [CHAR_CODE_WIDTH-1:0] CHAR_PRINT_HI  = 8'd127;

  // Result actions.
  localparam logic [ACTION_WIDTH-1:0] ACTION_DRAW      = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACTION_REDRAW    = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACTION_READ_DATA = 2'd2;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_CHAR       = 2'd0,
    KIND_CLEAR      = 2'd1,
    KIND_SET_CURSOR = 2'd2,
    KIND_READ       = 2'd3
  } tcw_kind_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ORIGIN_X    = 2'd0,
    CFG_CELL_WIDTH  = 2'd1,
    CFG_ORIGIN_Y    = 2'd2,
    CFG_CELL_HEIGHT = 2'd3
  } tcw_cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_EMIT
  } tcw_state_t;

endpackage

// File: src/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered; no dependencies.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/text_console_char_writer_core.sv
// Text console core: cursor control, scrolling ring of rows, draw and read requests.
// Depends on tcw_pkg and on tcw_ram for the character store.

// The character store is one ROWS x COLUMNS memory organized as a ring of rows.
// After reset the core writes zeros into every cell of the store and accepts no
// request in that time; configuration writes are taken at any time. A set-cursor
// request, an ignored byte and a newline that does not scroll leave the core idle
// and produce no result. A printable byte and a backspace inside a row write the
// store and then pass through the emit state; a cell read passes through the read
// state and then the emit state. A scroll blanks a row one cell per cycle through
// the single write port, and a backspace at column zero reads the row above back
// one cell per cycle to count its occupied cells. A clear request rewrites the
// whole store. A result waits in the emit state while the output is stalled and
// still holds the previous result. A finished result waits in the output
// register, so the next request is taken while it is still stalled.
module text_console_char_writer_core #(
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tcw_pkg::KIND_WIDTH-1:0]      kind,
  input  logic [tcw_pkg::CHAR_CODE_WIDTH-1:0] char_code,
  input  logic [tcw_pkg::COLUMN_WIDTH-1:0]    column,
  input  logic [tcw_pkg::ROW_WIDTH-1:0]       row,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcw_pkg::ACTION_WIDTH-1:0]    action,
  output logic [tcw_pkg::COLUMN_WIDTH-1:0]    cell_column,
  output logic [tcw_pkg::ROW_WIDTH-1:0]       cell_row,
  output logic [tcw_pkg::GLYPH_WIDTH-1:0]     glyph,
  output logic [tcw_pkg::PIXEL_X_WIDTH-1:0]   pixel_x,
  output logic [tcw_pkg::PIXEL_Y_WIDTH-1:0]   pixel_y
);

  import tcw_pkg::*;

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CCW   = (CW > COLUMN_WIDTH) ? CW : COLUMN_WIDTH;
  localparam int RCW   = (RW > ROW_WIDTH) ? RW : ROW_WIDTH;
  localparam int PXW   = CELL_SIZE_WIDTH + CW;
  localparam int PYW   = CELL_SIZE_WIDTH + RW;

  // Physical address of the first cell of a logical row.
  function automatic logic [AW-1:0] row_base(input logic [RW-1:0] r, input logic [RW-1:0] t);
    logic [RW:0] phys;
    phys = {1'b0, r} + {1'b0, t};
    if (phys >= (RW+1)'(ROWS)) begin
      phys = phys - (RW+1)'(ROWS);
    end
    return AW'(phys) * AW'(COLUMNS);
  endfunction

  // Control state
  tcw_state_t state, state_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [RW-1:0] top, top_next;
  logic [AW-1:0] sweep_addr, sweep_addr_next;
  logic [AW-1:0] sweep_last, sweep_last_next;
  logic [AW-1:0] scan_base, scan_base_next;
  logic [CW-1:0] scan_col, scan_col_next;
  logic [CW-1:0] scan_count, scan_count_next;
  logic          rd_pend;
  logic          res_pending, res_pending_next;

  // Pending result
  logic [ACTION_WIDTH-1:0] res_action, res_action_next;
  logic [CW-1:0]           res_col, res_col_next;
  logic [RW-1:0]           res_row, res_row_next;
  logic [GLYPH_WIDTH-1:0]  res_glyph, res_glyph_next;

  // Configuration registers
  logic [ORIGIN_WIDTH-1:0]    origin_x, origin_y;
  logic [CELL_SIZE_WIDTH-1:0] cell_width, cell_height;

  // Store port
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [GLYPH_WIDTH-1:0] ram_wdata, ram_rdata;

  // Request decode
  tcw_kind_t     kind_e;
  logic          in_accept;
  logic          is_bs, is_nl, is_print;
  logic          at_last_col, at_last_row;
  logic [CW-1:0] col_sat, scan_final;
  logic [RW-1:0] row_sat;
  logic [AW-1:0] cursor_addr;
  logic          out_load;
  logic          cfg_write;
  logic [PXW-1:0] px_prod;
  logic [PYW-1:0] py_prod;

  tcw_ram #(
    .WIDTH(GLYPH_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign kind_e    = tcw_kind_t'(kind);

  assign is_bs    = (char_code == CHAR_BACKSPACE);
  assign is_nl    = (char_code == CHAR_LF) || (char_code == CHAR_CR);
  assign is_print = (char_code >= CHAR_PRINT_LO) && (char_code <= CHAR_PRINT_HI);

  assign at_last_col = (cur_col >= CW'(COLUMNS - 1));
  assign at_last_row = (cur_row >= RW'(ROWS - 1));

  assign col_sat = (CCW'(column) > CCW'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(column);
  assign row_sat = (RCW'(row) > RCW'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(row);

  assign cursor_addr = row_base(cur_row, top) + AW'(cur_col);
  assign scan_final  = scan_count + CW'(ram_rdata != '0);
  assign out_load    = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (kind_e)
            KIND_CHAR: begin
              if (is_bs) begin
                if (cur_col != '0) begin
                  state_next = ST_EMIT;
                end else if (cur_row != '0) begin
                  state_next = ST_SCAN;
                end
              end else if (is_nl) begin
                if (at_last_row) begin
                  state_next = ST_SWEEP;
                end
              end else if (is_print) begin
                state_next = (at_last_col && at_last_row) ? ST_SWEEP : ST_EMIT;
              end
            end
            KIND_CLEAR:      state_next = ST_SWEEP;
            KIND_SET_CURSOR: state_next = ST_IDLE;
            KIND_READ:       state_next = ST_READ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sweep_addr == sweep_last) begin
          state_next = res_pending ? ST_EMIT : ST_IDLE;
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_SCAN: begin
        if (scan_col == CW'(COLUMNS - 1)) begin
          state_next = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_next = (scan_final != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    top_next         = top;
    sweep_addr_next  = sweep_addr;
    sweep_last_next  = sweep_last;
    scan_base_next   = scan_base;
    scan_col_next    = scan_col;
    scan_count_next  = scan_count;
    res_pending_next = res_pending;
    res_action_next  = res_action;
    res_col_next     = res_col;
    res_row_next     = res_row;
    res_glyph_next   = res_glyph;
    ram_we    = 1'b0;
    ram_waddr = cursor_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = scan_base + AW'(scan_col);

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (kind_e)
            KIND_CHAR: begin
              if (is_bs) begin
                if (cur_col != '0) begin
                  cur_col_next    = cur_col - CW'(1);
                  ram_we          = 1'b1;
                  ram_waddr       = cursor_addr - AW'(1);
                  res_action_next = ACTION_DRAW;
                  res_col_next    = cur_col - CW'(1);
                  res_row_next    = cur_row;
                  res_glyph_next  = '0;
                end else if (cur_row != '0) begin
                  // Count the occupied cells of the row above, skipping column zero.
                  cur_row_next    = cur_row - RW'(1);
                  scan_base_next  = row_base(cur_row - RW'(1), top);
                  scan_col_next   = CW'(1);
                  scan_count_next = '0;
                end
              end else if (is_nl || (is_print && at_last_col && at_last_row)) begin
                cur_col_next = '0;
                if (at_last_row) begin
                  // Blank the physical top row; it becomes the new bottom row.
                  sweep_addr_next  = row_base('0, top);
                  sweep_last_next  = row_base('0, top) + AW'(COLUMNS - 1);
                  top_next         = (top == RW'(ROWS - 1)) ? '0 : top + RW'(1);
                  cur_row_next     = RW'(ROWS - 1);
                  res_pending_next = 1'b1;
                  res_action_next  = ACTION_REDRAW;
                  res_col_next     = '0;
                  res_row_next     = '0;
                  res_glyph_next   = '0;
                end else begin
                  cur_row_next = cur_row + RW'(1);
                end
              end else if (is_print) begin
                ram_we          = 1'b1;
                ram_wdata       = GLYPH_WIDTH'(char_code);
                res_action_next = ACTION_DRAW;
                res_col_next    = cur_col;
                res_row_next    = cur_row;
                res_glyph_next  = GLYPH_WIDTH'(char_code);
                if (at_last_col) begin
                  cur_col_next = '0;
                  cur_row_next = cur_row + RW'(1);
                end else begin
                  cur_col_next = cur_col + CW'(1);
                end
              end
            end
            KIND_CLEAR: begin
              cur_col_next     = '0;
              cur_row_next     = '0;
              top_next         = '0;
              sweep_addr_next  = '0;
              sweep_last_next  = AW'(DEPTH - 1);
              res_pending_next = 1'b1;
              res_action_next  = ACTION_REDRAW;
              res_col_next     = '0;
              res_row_next     = '0;
              res_glyph_next   = '0;
            end
            KIND_SET_CURSOR: begin
              cur_col_next = col_sat;
              cur_row_next = row_sat;
            end
            KIND_READ: begin
              ram_re          = 1'b1;
              ram_raddr       = row_base(row_sat, top) + AW'(col_sat);
              res_action_next = ACTION_READ_DATA;
              res_col_next    = col_sat;
              res_row_next    = row_sat;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        ram_we          = 1'b1;
        ram_waddr       = sweep_addr;
        sweep_addr_next = sweep_addr + AW'(1);
      end
      ST_READ: begin
        res_glyph_next = ram_rdata;
      end
      ST_SCAN: begin
        ram_re        = 1'b1;
        scan_col_next = scan_col + CW'(1);
        if (rd_pend) begin
          scan_count_next = scan_final;
        end
      end
      ST_SCAN_LAST: begin
        cur_col_next = scan_final;
        if (scan_final != '0) begin
          ram_we          = 1'b1;
          ram_waddr       = scan_base + AW'(scan_final);
          res_action_next = ACTION_DRAW;
          res_col_next    = scan_final;
          res_row_next    = cur_row;
          res_glyph_next  = '0;
        end
      end
      ST_EMIT: begin
        res_pending_next = 1'b0;
      end
      default: begin
        res_pending_next = 1'b0;
      end
    endcase
  end

  assign px_prod = PXW'(cell_width) * PXW'(res_col);
  assign py_prod = PYW'(cell_height) * PYW'(res_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      cur_col     <= '0;
      cur_row     <= '0;
      top         <= '0;
      sweep_addr  <= '0;
      sweep_last  <= AW'(DEPTH - 1);
      scan_col    <= '0;
      scan_count  <= '0;
      rd_pend     <= 1'b0;
      res_pending <= 1'b0;
      out_valid   <= 1'b0;
      origin_x    <= ORIGIN_X_RESET;
      cell_width  <= CELL_WIDTH_RESET;
      origin_y    <= ORIGIN_Y_RESET;
      cell_height <= CELL_HEIGHT_RESET;
    end else begin
      state       <= state_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      top         <= top_next;
      sweep_addr  <= sweep_addr_next;
      sweep_last  <= sweep_last_next;
      scan_col    <= scan_col_next;
      scan_count  <= scan_count_next;
      rd_pend     <= (state == ST_SCAN);
      res_pending <= res_pending_next;
      out_valid   <= out_load || (out_valid && out_stall);
      if (cfg_write) begin
        unique case (tcw_cfg_index_t'(cfg_index))
          CFG_ORIGIN_X:    origin_x    <= cfg_data[ORIGIN_WIDTH-1:0];
          CFG_CELL_WIDTH:  cell_width  <= cfg_data[CELL_SIZE_WIDTH-1:0];
          CFG_ORIGIN_Y:    origin_y    <= cfg_data[ORIGIN_WIDTH-1:0];
          CFG_CELL_HEIGHT: cell_height <= cfg_data[CELL_SIZE_WIDTH-1:0];
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_base  <= scan_base_next;
    res_action <= res_action_next;
    res_col    <= res_col_next;
    res_row    <= res_row_next;
    res_glyph  <= res_glyph_next;
    if (out_load) begin
      action      <= res_action;
      cell_column <= COLUMN_WIDTH'(res_col);
      cell_row    <= ROW_WIDTH'(res_row);
      glyph       <= res_glyph;
      pixel_x     <= PIXEL_X_WIDTH'(origin_x) + PIXEL_X_WIDTH'(px_prod);
      pixel_y     <= PIXEL_Y_WIDTH'(origin_y) + PIXEL_Y_WIDTH'(py_prod);
    end
  end

  // The cursor and the ring offset always stay inside the text area.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= CW'(COLUMNS - 1)) && (cur_row <= RW'(ROWS - 1)) && (top <= RW'(ROWS - 1)))
    else $error("cursor or ring offset outside the text area");

  // Reads and writes never share a cycle, so no read-during-write bypass is needed.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  // A sweep never runs past its last address.
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (sweep_addr <= sweep_last))
    else $error("sweep address beyond its end");

  // A new result only appears after the emit state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result presented outside the emit state");

endmodule
